// ===== sv/biq_pkg.sv =====
// Shared types and constants for the biquad filter block.
`default_nettype none

package biq_pkg;

   localparam int COEF_BITS  = 18;
   localparam int CHAN_BITS  = 3;
   localparam int DELAY_BITS = 32;
   localparam int ROW_BITS   = 2 * DELAY_BITS;
   localparam int CSR_IDX_BITS = 3;

   localparam logic [CSR_IDX_BITS-1:0] REG_B0 = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_B1 = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_B2 = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_A1 = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_A2 = 3'd4;

   localparam logic signed [COEF_BITS-1:0] COEF_B0_RESET = 18'sd65536;
   localparam logic signed [COEF_BITS-1:0] COEF_ZERO     = 18'sd0;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

`default_nettype wire

// ===== sv/biq_delay_store.sv =====
// Per-channel delay store holding the two delay words of each channel.
`default_nettype none

module biq_delay_store #(
   parameter int NUM_CHANNELS = 8,
   localparam int ADDR_BITS = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire  biq_pkg::mem_ctl_type           ctl,
   input  wire  [ADDR_BITS-1:0]                 rd_addr,
   input  wire  [ADDR_BITS-1:0]                 wr_addr,
   input  wire  [biq_pkg::ROW_BITS-1:0]         wr_data,
   output logic [biq_pkg::ROW_BITS-1:0]         rd_data,
   output logic                                 rd_hit
);

   logic [biq_pkg::ROW_BITS-1:0] mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0]      valid_ff;
   logic [NUM_CHANNELS-1:0]      valid_in;
   logic [biq_pkg::ROW_BITS-1:0] rd_data_ff;
   logic                         rd_hit_ff;

   // A row that was never written since reset reads with rd_hit low; the filter then uses zero delay words.
   always_comb begin
      valid_in = valid_ff;
      if (ctl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ctl.rd_en) begin
            rd_hit_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign rd_hit  = rd_hit_ff;

endmodule

`default_nettype wire

// ===== sv/biquad_df2_filter.sv =====
// Multichannel Direct Form II biquad filter on one shared multiply-accumulate unit.
//
//   Channel  | Handshake            | Payload
//   ---------+----------------------+-----------------------------------
//   req      | req_valid/req_ready  | req_sample_in, req_chan
//   rsp      | rsp_valid/rsp_ready  | rsp_sample_out, rsp_chan_out
//   csr      | csr_we (no wait)     | csr_index, csr_wdata
//
// The block takes no new item until the last one is through its sequence: one delay store
// read, five products on the single 18x32 multiplier with their accumulations, and
// two rounding steps. The result is held in an output register, so the next item
// can be accepted while it waits; if it is still held when the next result is ready,
// the sequencer waits. Reset clears the delay store valid bits, so no clearing pass.
`default_nettype none

module biquad_df2_filter #(
   parameter int NUM_CHANNELS   = 8,
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  signed [SAMPLE_BITS-1:0]      req_sample_in,
   input  wire  [biq_pkg::CHAN_BITS-1:0]      req_chan,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]      rsp_sample_out,
   output logic [biq_pkg::CHAN_BITS-1:0]      rsp_chan_out,
   input  wire                                csr_we,
   input  wire  [biq_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire  [biq_pkg::COEF_BITS-1:0]      csr_wdata
);

   localparam int ADDR_BITS = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CHAN_EXT_BITS = (ADDR_BITS > biq_pkg::CHAN_BITS) ?
                                  ADDR_BITS : biq_pkg::CHAN_BITS;
   localparam int ACC_BITS  = 64;
   localparam int PROD_BITS = biq_pkg::COEF_BITS + biq_pkg::DELAY_BITS;
   localparam int DB        = biq_pkg::DELAY_BITS;

   localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
      ACC_BITS'(64'sd1 <<< (COEF_FRAC_BITS - 1));
   localparam logic signed [ACC_BITS-1:0] W_MAX = ACC_BITS'((64'sd1 <<< (DB - 1)) - 1);
   localparam logic signed [ACC_BITS-1:0] W_MIN = -W_MAX - 1;
   localparam logic signed [ACC_BITS-1:0] Y_MAX =
      ACC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [ACC_BITS-1:0] Y_MIN = -Y_MAX - 1;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_LOAD  = 4'd1;
   localparam logic [3:0] ST_MA1   = 4'd2;
   localparam logic [3:0] ST_MA2   = 4'd3;
   localparam logic [3:0] ST_AW    = 4'd4;
   localparam logic [3:0] ST_RNDW  = 4'd5;
   localparam logic [3:0] ST_MB2   = 4'd6;
   localparam logic [3:0] ST_MB0   = 4'd7;
   localparam logic [3:0] ST_AY    = 4'd8;
   localparam logic [3:0] ST_RNDY  = 4'd9;

   logic [3:0] state_ff, state_in;

   logic signed [biq_pkg::COEF_BITS-1:0] b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;

   logic signed [SAMPLE_BITS-1:0]   x_ff;
   logic [biq_pkg::CHAN_BITS-1:0]   chan_ff;
   logic [ADDR_BITS-1:0]            addr_ff;
   logic                            chan_ok_ff;
   logic signed [DB-1:0]            w1_ff, w2_ff, w_ff;
   logic signed [ACC_BITS-1:0]      acc_ff, acc_in;
   logic signed [PROD_BITS-1:0]     prod_ff;

   logic signed [biq_pkg::COEF_BITS-1:0] mul_coef;
   logic signed [DB-1:0]                 mul_op;
   logic signed [PROD_BITS-1:0]          mul_prod;
   logic signed [ACC_BITS-1:0]           prod_ext;

   logic signed [ACC_BITS-1:0]      rnd_sum, rnd_q;
   logic signed [DB-1:0]            w_sat;
   logic signed [SAMPLE_BITS-1:0]   y_sat;

   logic                            rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0]   rsp_sample_ff;
   logic [biq_pkg::CHAN_BITS-1:0]   rsp_chan_ff;

   logic                            accept;
   logic                            out_load;
   logic [CHAN_EXT_BITS-1:0]        chan_wide;
   logic [ADDR_BITS-1:0]            req_addr;
   logic                            req_chan_ok;

   biq_pkg::mem_ctl_type            mem_ctl;
   logic [biq_pkg::ROW_BITS-1:0]    mem_rd_data;
   logic                            mem_rd_hit;

   assign accept      = req_valid && req_ready;
   assign req_ready   = (state_ff == ST_IDLE);
   assign chan_wide   = CHAN_EXT_BITS'(req_chan);
   assign req_addr    = chan_wide[ADDR_BITS-1:0];
   assign req_chan_ok = (32'(req_chan) < NUM_CHANNELS);
   assign out_load    = (state_ff == ST_RNDY) && (!rsp_valid_ff || rsp_ready);

   assign mem_ctl = '{rd_en: accept, wr_en: (state_ff == ST_MB2) && chan_ok_ff};

   biq_delay_store #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_delay_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .rd_addr (req_addr),
      .wr_addr (addr_ff),
      .wr_data ({w_ff, w1_ff}),
      .rd_data (mem_rd_data),
      .rd_hit  (mem_rd_hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff <= biq_pkg::COEF_B0_RESET;
         b1_ff <= biq_pkg::COEF_ZERO;
         b2_ff <= biq_pkg::COEF_ZERO;
         a1_ff <= biq_pkg::COEF_ZERO;
         a2_ff <= biq_pkg::COEF_ZERO;
      end else if (csr_we) begin
         unique case (csr_index)
            biq_pkg::REG_B0: b0_ff <= csr_wdata;
            biq_pkg::REG_B1: b1_ff <= csr_wdata;
            biq_pkg::REG_B2: b2_ff <= csr_wdata;
            biq_pkg::REG_A1: a1_ff <= csr_wdata;
            biq_pkg::REG_A2: a2_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (state_ff)
         ST_MA1:  begin mul_coef = a1_ff; mul_op = w1_ff; end
         ST_MA2:  begin mul_coef = a2_ff; mul_op = w2_ff; end
         ST_RNDW: begin mul_coef = b1_ff; mul_op = w1_ff; end
         ST_MB2:  begin mul_coef = b2_ff; mul_op = w2_ff; end
         default: begin mul_coef = b0_ff; mul_op = w_ff;  end
      endcase
   end

   assign mul_prod = mul_coef * mul_op;
   assign prod_ext = {{(ACC_BITS - PROD_BITS){prod_ff[PROD_BITS-1]}}, prod_ff};

   // Round half up, then floor-divide by the coefficient scale.
   assign rnd_sum = acc_ff + ROUND_HALF;
   assign rnd_q   = rnd_sum >>> COEF_FRAC_BITS;

   always_comb begin
      if (rnd_q > W_MAX) begin
         w_sat = W_MAX[DB-1:0];
      end else if (rnd_q < W_MIN) begin
         w_sat = W_MIN[DB-1:0];
      end else begin
         w_sat = rnd_q[DB-1:0];
      end
      if (rnd_q > Y_MAX) begin
         y_sat = Y_MAX[SAMPLE_BITS-1:0];
      end else if (rnd_q < Y_MIN) begin
         y_sat = Y_MIN[SAMPLE_BITS-1:0];
      end else begin
         y_sat = rnd_q[SAMPLE_BITS-1:0];
      end
   end

   always_comb begin
      acc_in   = acc_ff;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            acc_in   = {{(ACC_BITS - SAMPLE_BITS){x_ff[SAMPLE_BITS-1]}}, x_ff}
                       <<< COEF_FRAC_BITS;
            state_in = ST_MA1;
         end
         ST_MA1: state_in = ST_MA2;
         ST_MA2: begin
            acc_in   = acc_ff - prod_ext;
            state_in = ST_AW;
         end
         ST_AW: begin
            acc_in   = acc_ff - prod_ext;
            state_in = ST_RNDW;
         end
         ST_RNDW: begin
            acc_in   = '0;
            state_in = ST_MB2;
         end
         ST_MB2: begin
            acc_in   = acc_ff + prod_ext;
            state_in = ST_MB0;
         end
         ST_MB0: begin
            acc_in   = acc_ff + prod_ext;
            state_in = ST_AY;
         end
         ST_AY: begin
            acc_in   = acc_ff + prod_ext;
            state_in = ST_RNDY;
         end
         ST_RNDY: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      prod_ff <= mul_prod;
      if (accept) begin
         x_ff       <= req_sample_in;
         chan_ff    <= req_chan;
         addr_ff    <= req_addr;
         chan_ok_ff <= req_chan_ok;
      end
      if (state_ff == ST_LOAD) begin
         if (chan_ok_ff && mem_rd_hit) begin
            w1_ff <= mem_rd_data[biq_pkg::ROW_BITS-1:DB];
            w2_ff <= mem_rd_data[DB-1:0];
         end else begin
            w1_ff <= '0;
            w2_ff <= '0;
         end
      end
      if (state_ff == ST_RNDW) begin
         w_ff <= w_sat;
      end
      if (out_load) begin
         rsp_sample_ff <= y_sat;
         rsp_chan_ff   <= chan_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_chan_out   = rsp_chan_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("Block still ready in the cycle after taking an item.");

   a_result_from_last_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RNDY)
      else $error("Result appeared outside the final rounding step.");

   a_store_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.wr_en |-> $past(state_ff) == ST_RNDW && 32'(chan_ff) < NUM_CHANNELS)
      else $error("Delay store written out of sequence or for an absent channel.");

endmodule

`default_nettype wire

// ===== tb/sv/biquad_df2_filter_tb.sv =====
// Self-checking testbench for the multichannel biquad filter under random handshake stalls.
module biquad_df2_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_BITS   = 24;
   localparam int FRAC_BITS     = 16;
   localparam int NUM_CHANNELS  = 8;
   localparam int SETTLE_CYCLES = 14;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_ITEMS   = 200;

   typedef logic signed [SAMPLE_BITS-1:0]          sample_type;
   typedef logic [biq_pkg::CHAN_BITS-1:0]          chan_type;
   typedef logic [biq_pkg::COEF_BITS-1:0]          coef_type;
   typedef logic [biq_pkg::CSR_IDX_BITS-1:0]       reg_idx_type;

   typedef struct {
      sample_type sample;
      chan_type   chan;
   } filter_out_type;

   class biquad_scoreboard;
      longint b0, b1, b2, a1, a2;
      longint delay_one [NUM_CHANNELS];
      longint delay_two [NUM_CHANNELS];
      filter_out_type expected_outputs [$];
      int errors;
      int checked;
      int accepted;

      function new();
         b0 = longint'(biq_pkg::COEF_B0_RESET);
         b1 = longint'(biq_pkg::COEF_ZERO);
         b2 = longint'(biq_pkg::COEF_ZERO);
         a1 = longint'(biq_pkg::COEF_ZERO);
         a2 = longint'(biq_pkg::COEF_ZERO);
         foreach (delay_one[i]) begin
            delay_one[i] = 0;
            delay_two[i] = 0;
         end
         errors = 0;
         checked = 0;
         accepted = 0;
      endfunction

      function void set_coef(reg_idx_type idx, coef_type value);
         longint v;
         v = longint'($signed(value));
         case (idx)
            biq_pkg::REG_B0: b0 = v;
            biq_pkg::REG_B1: b1 = v;
            biq_pkg::REG_B2: b2 = v;
            biq_pkg::REG_A1: a1 = v;
            biq_pkg::REG_A2: a2 = v;
            default: ;
         endcase
      endfunction

      // Round half up at the binary point, then clamp to a signed range of the given width.
      function longint round_sat(longint acc, int bits);
         longint v, hi;
         v = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
         hi = (longint'(1) <<< (bits - 1)) - 1;
         if (v > hi) return hi;
         if (v < -hi - 1) return -hi - 1;
         return v;
      endfunction

      function void note_sample(sample_type x, chan_type ch);
         longint w1, w2, w, y, acc;
         filter_out_type result;
         w1 = 0;
         w2 = 0;
         if (int'(ch) < NUM_CHANNELS) begin
            w1 = delay_one[ch];
            w2 = delay_two[ch];
         end
         acc = (longint'(x) <<< FRAC_BITS) - a1 * w1 - a2 * w2;
         w = round_sat(acc, 32);
         acc = b0 * w + b1 * w1 + b2 * w2;
         y = round_sat(acc, SAMPLE_BITS);
         if (int'(ch) < NUM_CHANNELS) begin
            delay_two[ch] = w1;
            delay_one[ch] = w;
         end
         result.sample = sample_type'(y);
         result.chan = ch;
         expected_outputs.push_back(result);
         accepted++;
      endfunction

      function void check_output(sample_type s, chan_type c);
         filter_out_type want;
         checked++;
         if (expected_outputs.size() == 0) begin
            errors++;
            $error("unexpected output item: sample_out %0d chan_out %0d", s, c);
            return;
         end
         want = expected_outputs.pop_front();
         if (s !== want.sample) begin
            errors++;
            $error("sample_out mismatch: expected %0d, actual %0d", want.sample, s);
         end
         if (c !== want.chan) begin
            errors++;
            $error("chan_out mismatch: expected %0d, actual %0d", want.chan, c);
         end
      endfunction

      function int pending();
         return expected_outputs.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   sample_type  req_sample_in;
   chan_type    req_chan;
   logic        rsp_valid;
   logic        rsp_ready;
   sample_type  rsp_sample_out;
   chan_type    rsp_chan_out;
   logic        csr_we;
   reg_idx_type csr_index;
   coef_type    csr_wdata;

   biquad_scoreboard board = new();
   int send_idle_pct = 30;
   int recv_idle_pct = 69;
   bit long_hold_request = 1'b0;
   int settings_used = 0;

   biquad_df2_filter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .req_chan       (req_chan),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_chan_out   (rsp_chan_out),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_output(rsp_sample_out, rsp_chan_out);
   end

   task automatic send_sample(sample_type x, chan_type ch);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= x;
      req_chan <= ch;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_sample(x, ch);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes all five coefficients, then one write to an unused index that must be ignored.
   task automatic write_coefs(coef_type b0, coef_type b1, coef_type b2, coef_type a1,
                              coef_type a2);
      reg_idx_type regs [6];
      coef_type vals [6];
      regs = '{biq_pkg::REG_B0, biq_pkg::REG_B1, biq_pkg::REG_B2, biq_pkg::REG_A1,
               biq_pkg::REG_A2, reg_idx_type'(biq_pkg::REG_A2 + $urandom_range(1, 3))};
      vals = '{b0, b1, b2, a1, a2, coef_type'($urandom)};
      for (int i = 0; i < 6; i++) begin
         csr_we <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(negedge clock);
         board.set_coef(regs[i], vals[i]);
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   function automatic coef_type pick_coef(int kind);
      case (kind)
         0: return coef_type'($urandom);
         1: return coef_type'(int'($urandom_range(65536)) - 32768);
         default: begin
            case ($urandom_range(4))
               0: return coef_type'(-131072);
               1: return coef_type'(131071);
               2: return coef_type'(0);
               3: return coef_type'(65536);
               default: return coef_type'(-1);
            endcase
         end
      endcase
   endfunction

   function automatic sample_type pick_sample();
      case ($urandom_range(9))
         0: return $urandom_range(1) ? sample_type'(8388607) : sample_type'(-8388608);
         1: return sample_type'(int'($urandom_range(64)) - 32);
         default: return sample_type'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      sample_type pass_vals [8];
      sample_type half_vals [4];
      pass_vals = '{sample_type'(8388607), sample_type'(-8388608), sample_type'(0),
                    sample_type'(-1), sample_type'(1), sample_type'(24'h555555),
                    sample_type'(24'hAAAAAA), sample_type'(24'h0F0F0F)};
      half_vals = '{sample_type'(1), sample_type'(-1), sample_type'(3), sample_type'(-3)};

      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_in = '0;
      req_chan = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset coefficients pass each sample straight through.
      for (int i = 0; i < 8; i++) send_sample(pass_vals[i], chan_type'(i));
      settle();

      // Extreme, unstable coefficients drive both the delay words and the output into saturation.
      write_coefs(coef_type'(131071), coef_type'(131071), coef_type'(-131072),
                  coef_type'(-131072), coef_type'(131071));
      for (int i = 0; i < 4; i++) begin
         send_sample(sample_type'(8388607), chan_type'(0));
         send_sample(sample_type'(-8388608), chan_type'(1));
      end
      settle();

      // A gain of one half puts results exactly on a half, which must round upward.
      write_coefs(coef_type'(32768), coef_type'(0), coef_type'(0), coef_type'(0),
                  coef_type'(0));
      for (int i = 0; i < 4; i++) send_sample(half_vals[i], chan_type'(i + 2));

      for (int p = 0; p < 8; p++) begin
         settle();
         if (p == 3) begin
            send_idle_pct = 69;
            recv_idle_pct = 30;
         end
         if (p == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            long_hold_request = 1'b1;
         end
         write_coefs(pick_coef(p % 3), pick_coef(p % 3), pick_coef(p % 3),
                     pick_coef(p % 3), pick_coef(p % 3));
         repeat (PHASE_ITEMS) send_sample(pick_sample(), chan_type'($urandom_range(7)));
      end

      settle();
      repeat (20) @(posedge clock);
      $display("Filtered %0d samples on all channels under %0d coefficient settings.",
               board.accepted, settings_used);
      $display("Checked %0d outputs across sender and receiver stalls and one long hold-off.",
               board.checked);
      if (board.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/biq_pkg.sv
sv/biq_delay_store.sv
sv/biquad_df2_filter.sv
tb/sv/biquad_df2_filter_tb.sv
